[rtl/csm_pkg.sv]
package csm_pkg;

   // Width of the class id as compared and stored.
   localparam int CLASS_BITS = 32;

   // Fixed field widths on the ports.
   localparam int ID_BITS   = 32;
   localparam int TYPE_BITS = 2;
   localparam int REQ_BITS  = 32;
   localparam int RSP_BITS  = 40;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Entry type codes.
   localparam logic [TYPE_BITS-1:0] T_SINGLE    = 2'd0;
   localparam logic [TYPE_BITS-1:0] T_CLUSTER   = 2'd1;
   localparam logic [TYPE_BITS-1:0] T_BRIDGED   = 2'd2;
   localparam logic [TYPE_BITS-1:0] T_CROSSOVER = 2'd3;

   typedef logic [3:0][CLASS_BITS-1:0] cls_win_type;
   typedef logic [3:0][TYPE_BITS-1:0]  typ_win_type;

   // One queue entry: up to four finalized entries, oldest in slot 0.
   typedef struct packed {
      logic        run_end;
      logic [1:0]  last_idx;
      cls_win_type cls;
      typ_win_type typ;
   } bundle_type;

   // Push side of the queue.
   typedef struct packed {
      logic       valid;
      bundle_type data;
   } push_type;

   // Pattern scan at window position k with m entries held.
   function automatic typ_win_type csm_scan(cls_win_type cls, typ_win_type typ,
                                             logic [1:0] k, logic [2:0] m);
      typ_win_type t;
      logic [1:0]  k1;
      logic [1:0]  k2;
      logic [1:0]  k3;
      logic [2:0]  kx;
      t  = typ;
      k1 = k + 2'd1;
      k2 = k + 2'd2;
      k3 = k + 2'd3;
      kx = {1'b0, k};
      if ((kx + 3'd1 < m) && (k != 2'd3)) begin
         if (cls[k] == cls[k1]) begin
            t[k]  = T_CLUSTER;
            t[k1] = T_CLUSTER;
         end else if ((kx + 3'd2 < m) && (cls[k] == cls[k2])) begin
            if ((t[k1] == T_BRIDGED) || (t[k1] == T_CROSSOVER)) begin
               // chained bridge
               t[k]  = T_CROSSOVER;
               t[k1] = T_CROSSOVER;
               t[k2] = T_CROSSOVER;
            end else if ((kx + 3'd3 < m) && (t[k] != T_CLUSTER) &&
                         (cls[k1] == cls[k3])) begin
               // A-B-A-B
               t[k]  = T_CROSSOVER;
               t[k1] = T_CROSSOVER;
               t[k2] = T_CROSSOVER;
               t[k3] = T_CROSSOVER;
            end else begin
               if ((t[k] != T_CLUSTER) && (t[k] != T_CROSSOVER)) begin
                  t[k] = T_BRIDGED;
               end
               t[k2] = T_BRIDGED;
            end
         end
      end
      return t;
   endfunction

endpackage

[rtl/csm_front.sv]
module csm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [csm_pkg::ID_BITS-1:0] class_id,
   input  logic                      last,
   output csm_pkg::push_type         push
);
   import csm_pkg::*;

   cls_win_type cls_ff, cls_in;
   typ_win_type typ_ff, typ_in;
   logic [1:0]  fill_ff, fill_in;

   cls_win_type w_cls;
   typ_win_type w_typ;
   typ_win_type typ_s0;
   typ_win_type typ_s1;
   typ_win_type typ_s2;
   logic [2:0]  m;
   logic [63:0] id_wide;

   always_comb begin
      m       = {1'b0, fill_ff} + 3'd1;
      id_wide = 64'(class_id);
      w_cls   = cls_ff;
      w_typ   = typ_ff;
      w_cls[fill_ff] = id_wide[CLASS_BITS-1:0];
      w_typ[fill_ff] = T_SINGLE;

      // Scans run in window order; each sees the labels left by the one before.
      typ_s0 = csm_scan(w_cls, w_typ, 2'd0, m);
      typ_s1 = csm_scan(w_cls, typ_s0, 2'd1, m);
      typ_s2 = csm_scan(w_cls, typ_s1, 2'd2, m);

      push.valid         = accept && (last || (m == 3'd4));
      push.data.run_end  = last;
      push.data.last_idx = last ? fill_ff : 2'd0;
      push.data.cls      = w_cls;
      push.data.typ      = last ? typ_s2 : typ_s0;

      cls_in  = cls_ff;
      typ_in  = typ_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (last) begin
            cls_in  = '0;
            typ_in  = '0;
            fill_in = 2'd0;
         end else if (m == 3'd4) begin
            // drop the oldest entry, advance the window
            cls_in  = {{CLASS_BITS{1'b0}}, w_cls[3], w_cls[2], w_cls[1]};
            typ_in  = {T_SINGLE, typ_s0[3], typ_s0[2], typ_s0[1]};
            fill_in = 2'd3;
         end else begin
            cls_in  = w_cls;
            typ_in  = w_typ;
            fill_in = m[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff  <= '0;
         typ_ff  <= '0;
         fill_ff <= 2'd0;
      end else begin
         cls_ff  <= cls_in;
         typ_ff  <= typ_in;
         fill_ff <= fill_in;
      end
   end

endmodule

[rtl/csm_queue.sv]
module csm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  csm_pkg::push_type     push,
   output logic                  full,
   output logic                  head_valid,
   output csm_pkg::bundle_type   head,
   input  logic                  pop
);
   import csm_pkg::*;

   bundle_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/csm_back.sv]
module csm_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  csm_pkg::bundle_type          head,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [csm_pkg::RSP_BITS-1:0] rsp_tdata,
   output logic                         rsp_tlast
);
   import csm_pkg::*;

   logic [1:0]           idx_ff, idx_in;
   logic [63:0]          cls_wide;
   logic [TYPE_BITS-1:0] ty;
   logic                 keep;
   logic                 at_end;
   logic                 xfer;

   always_comb begin
      cls_wide   = 64'(head.cls[idx_ff]);
      ty         = head.typ[idx_ff];
      keep       = (ty == T_CLUSTER) || (ty == T_BRIDGED);
      at_end     = (idx_ff == head.last_idx);
      rsp_tvalid = head_valid;
      rsp_tdata  = {5'd0, keep, ty, cls_wide[ID_BITS-1:0]};
      rsp_tlast  = head.run_end && at_end;
      xfer       = rsp_tvalid && rsp_tready;
      pop        = xfer && at_end;
      idx_in     = idx_ff;
      if (xfer) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[rtl/class_run_singleton_marker_unit.sv]
// Channel | Dir | Signals                         | Payload
// req     | in  | req_tvalid/tready/tdata/tlast   | class_id, last entry of run on tlast
// rsp     | out | rsp_tvalid/tready/tdata/tlast   | entry_class, entry_type, keep; run_end on tlast
//
// One entry is taken per cycle while the queue is not full; in steady state each accepted
// entry yields one transfer on rsp, so the block sustains one item per cycle when neither side stalls.
// The last entry of a run releases up to four results, one per cycle while rsp is ready; the back
// part serializes them, and the front stalls only once its two-deep queue is full.
// Reset (synchronous, active high) clears the window, the labels and the queue.
// Either side may stall independently; the queue between them holds the results.
module class_run_singleton_marker_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [csm_pkg::REQ_BITS-1:0] req_tdata,   // [31:0] class_id
   input  logic                         req_tlast,   // last entry of the run
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [csm_pkg::RSP_BITS-1:0] rsp_tdata,   // [31:0] entry_class, [33:32] entry_type,
                                                     // [34] keep, [39:35] zero
   output logic                         rsp_tlast    // run_end
);
   import csm_pkg::*;

   push_type   push;
   bundle_type head;
   logic       full;
   logic       head_valid;
   logic       pop;
   logic       accept;

   // Take a new entry whenever the queue has room for what it may release.
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   // Front: hold the look-ahead window, scan it, and finalize entries.
   csm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .class_id (req_tdata[ID_BITS-1:0]),
      .last     (req_tlast),
      .push     (push)
   );

   // Queue: decouple the front from result stalls.
   csm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // Back: emit the finalized entries of each queue slot in order.
   csm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
